// ===== src/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg: shared constants and types of the open addressing hash table
// Table geometry, field widths and the result status codes.
// ----------------------------------------------------------------------------
package oaht_pkg;

   // table geometry
   localparam int SLOTS     = 1024;
   localparam int DATA_BITS = 64;

   // slot index width and probe counter width (counter holds SLOTS itself)
   localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PROBE_W = $clog2(SLOTS + 1);

   // field widths of the channels
   localparam int KEY_W     = 64;
   localparam int PAYLOAD_W = 64;
   localparam int CNT_W     = 11;
   localparam int OVR_W     = 32;
   localparam int SUM_W     = 48;

   // home slot is a plain mask when the slot count is a power of two
   localparam bit SLOTS_POW2 = (SLOTS & (SLOTS - 1)) == 0;

   // the table can only report full when the fill counter can reach SLOTS
   localparam bit FULL_REACHABLE = SLOTS <= ((1 << CNT_W) - 1);

   typedef enum logic [1:0] {
      STATUS_STORED   = 2'd0,
      STATUS_OVERRIDE = 2'd1,
      STATUS_HIT      = 2'd2,
      STATUS_MISS     = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

endpackage

// ===== src/open_addressing_hash_table.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table: fixed-slot hash table with open addressing
// Inserts and grouped lookups walk the slot memory one read per probe under
// a small sequencer; one adder advances the probe index.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/req_stall func, key, payload, group_last
//   rsp_      out        rsp_valid/rsp_stall status, found_data, probe_count,
//                                            fill_count, override_total
//
// Each probe is one slot memory read (ST_READ) followed by one compare
// (ST_CHECK). With a slot count that is not a power of two the home slot is
// first reduced one key bit per cycle in ST_HASH, before the first read.
// After reset a clearing pass writes every valid bit while req_stall stays
// high. req_stall is high whenever an item is in progress; a finished beat
// waits in the output register while rsp_stall is high.
// ----------------------------------------------------------------------------
module open_addressing_hash_table
   import oaht_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_func,
   input  logic [KEY_W-1:0]     req_key,
   input  logic [PAYLOAD_W-1:0] req_payload,
   input  logic                 req_group_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [PAYLOAD_W-1:0] rsp_found_data,
   output logic [CNT_W-1:0]     rsp_probe_count,
   output logic [CNT_W-1:0]     rsp_fill_count,
   output logic [OVR_W-1:0]     rsp_override_total
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK
   } state_type;

   // slot memories
   logic                 mem_valid [SLOTS];
   logic [KEY_W-1:0]     mem_key   [SLOTS];
   logic [DATA_BITS-1:0] mem_data  [SLOTS];

   // sequencer state
   state_type            state_ff;
   logic [ADDR_W-1:0]    idx_ff;
   logic [PROBE_W-1:0]   probe_ff;
   logic [5:0]           bit_ff;

   // held request
   logic                 func_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [DATA_BITS-1:0] payload_ff;
   logic                 last_ff;
   logic                 full_ff;

   // registered slot read
   logic                 rd_valid_ff;
   logic [KEY_W-1:0]     rd_key_ff;
   logic [DATA_BITS-1:0] rd_data_ff;

   // table counters
   logic [CNT_W-1:0]     entry_count_ff;
   logic [CNT_W-1:0]     entry_count_in;
   logic [OVR_W-1:0]     override_ff;
   logic [OVR_W-1:0]     override_in;
   logic [SUM_W-1:0]     probe_sum_ff;
   logic [SUM_W-1:0]     probe_sum_in;
   logic                 group_hit_ff;

   // output register
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [PAYLOAD_W-1:0] rsp_found_data_ff;
   logic [CNT_W-1:0]     rsp_probe_count_ff;
   logic [CNT_W-1:0]     rsp_fill_count_ff;
   logic [OVR_W-1:0]     rsp_override_total_ff;

   // datapath
   logic                 accept;
   logic                 out_free;
   logic                 match;
   logic                 limit;
   logic                 stop;
   logic                 finish;
   logic                 ovr;
   logic                 emit;
   logic                 slot_we;
   logic                 valid_we;
   logic [ADDR_W:0]      probe_sum_idx;
   logic [ADDR_W-1:0]    next_idx;
   logic [ADDR_W:0]      hash_shift;
   logic [ADDR_W-1:0]    hash_rem;
   logic [SUM_W:0]       sum_wide;

   assign req_stall          = (state_ff != ST_IDLE);
   assign accept             = req_valid && (state_ff == ST_IDLE);
   assign out_free           = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_data     = rsp_found_data_ff;
   assign rsp_probe_count    = rsp_probe_count_ff;
   assign rsp_fill_count     = rsp_fill_count_ff;
   assign rsp_override_total = rsp_override_total_ff;

   // compare the read slot and decide whether the walk ends here
   always_comb begin
      match = rd_valid_ff && (rd_key_ff == key_ff);
      limit = (probe_ff == PROBE_W'(SLOTS));
      if (func_ff == FUNC_LOOKUP) begin
         stop = match || limit;
      end else begin
         stop = !rd_valid_ff || full_ff || limit;
      end
      finish = (state_ff == ST_CHECK) && stop && out_free;
      ovr    = full_ff || limit;
   end

   // probe adder: advance the probe index, wrap by one subtract
   always_comb begin
      probe_sum_idx = (ADDR_W + 1)'(idx_ff) + (ADDR_W + 1)'(probe_ff);
      if (probe_sum_idx >= (ADDR_W + 1)'(SLOTS)) begin
         next_idx = ADDR_W'(probe_sum_idx - (ADDR_W + 1)'(SLOTS));
      end else begin
         next_idx = ADDR_W'(probe_sum_idx);
      end
   end

   // home slot reduction, one key bit a cycle
   always_comb begin
      hash_shift = {idx_ff, key_ff[bit_ff]};
      if (hash_shift >= (ADDR_W + 1)'(SLOTS)) begin
         hash_rem = ADDR_W'(hash_shift - (ADDR_W + 1)'(SLOTS));
      end else begin
         hash_rem = ADDR_W'(hash_shift);
      end
   end

   // memory write enables
   always_comb begin
      slot_we  = finish && (func_ff == FUNC_INSERT);
      valid_we = slot_we || (state_ff == ST_CLEAR);
   end

   // next counter values for an insert that ends this cycle
   always_comb begin
      entry_count_in = entry_count_ff;
      override_in    = override_ff;
      probe_sum_in   = probe_sum_ff;
      if (slot_we) begin
         sum_wide = (SUM_W + 1)'(probe_sum_ff) + (SUM_W + 1)'(probe_ff);
         if (sum_wide[SUM_W]) begin
            probe_sum_in = '1;
         end else begin
            probe_sum_in = sum_wide[SUM_W-1:0];
         end
         if (ovr) begin
            if (override_ff != '1) begin
               override_in = override_ff + OVR_W'(1);
            end
         end else if (entry_count_ff != '1) begin
            entry_count_in = entry_count_ff + CNT_W'(1);
         end
      end else begin
         sum_wide = '0;
      end
      emit = finish && ((func_ff == FUNC_INSERT) || !limit || last_ff);
   end

   // slot memories: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (valid_we) begin
         mem_valid[idx_ff] <= slot_we;
      end
      if (slot_we) begin
         mem_key[idx_ff]  <= key_ff;
         mem_data[idx_ff] <= payload_ff;
      end
      if (state_ff == ST_READ) begin
         rd_valid_ff <= mem_valid[idx_ff];
         rd_key_ff   <= mem_key[idx_ff];
         rd_data_ff  <= mem_data[idx_ff];
      end
   end

   // sequencer, counters and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         idx_ff         <= '0;
         probe_ff       <= '0;
         bit_ff         <= '0;
         entry_count_ff <= '0;
         override_ff    <= '0;
         probe_sum_ff   <= '0;
         group_hit_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_count_ff <= entry_count_in;
         override_ff    <= override_in;
         probe_sum_ff   <= probe_sum_in;

         // drop the output beat once taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (idx_ff == ADDR_W'(SLOTS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + ADDR_W'(1);
               end
            end
            ST_IDLE: begin
               if (accept) begin
                  if ((req_func == FUNC_LOOKUP) && group_hit_ff) begin
                     // skip the rest of a group that already hit
                     if (req_group_last) begin
                        group_hit_ff <= 1'b0;
                     end
                  end else begin
                     func_ff    <= req_func;
                     key_ff     <= req_key;
                     payload_ff <= DATA_BITS'(req_payload);
                     last_ff    <= req_group_last;
                     full_ff    <= FULL_REACHABLE &&
                                   (entry_count_ff == CNT_W'(SLOTS));
                     probe_ff   <= '0;
                     if (SLOTS_POW2) begin
                        idx_ff   <= req_key[ADDR_W-1:0];
                        state_ff <= ST_READ;
                     end else begin
                        idx_ff   <= '0;
                        bit_ff   <= 6'd63;
                        state_ff <= ST_HASH;
                     end
                  end
               end
            end
            ST_HASH: begin
               idx_ff <= hash_rem;
               bit_ff <= bit_ff - 6'd1;
               if (bit_ff == 6'd0) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (!stop) begin
                  // advance to the next probe
                  idx_ff   <= next_idx;
                  probe_ff <= probe_ff + PROBE_W'(1);
                  state_ff <= ST_READ;
               end else if (out_free) begin
                  state_ff <= ST_IDLE;
                  if ((func_ff == FUNC_LOOKUP) && !limit) begin
                     group_hit_ff <= !last_ff;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         // load the result beat
         if (emit) begin
            rsp_valid_ff          <= 1'b1;
            rsp_probe_count_ff    <= CNT_W'(probe_ff);
            rsp_fill_count_ff     <= entry_count_in;
            rsp_override_total_ff <= override_in;
            if (func_ff == FUNC_INSERT) begin
               rsp_status_ff     <= ovr ? STATUS_OVERRIDE : STATUS_STORED;
               rsp_found_data_ff <= '0;
            end else if (!limit) begin
               rsp_status_ff     <= STATUS_HIT;
               rsp_found_data_ff <= PAYLOAD_W'(rd_data_ff);
            end else begin
               rsp_status_ff     <= STATUS_MISS;
               rsp_found_data_ff <= '0;
            end
         end
      end
   end

endmodule
